@@ rtl/agqfd_pkg.sv @@
`default_nettype none

package agqfd_pkg;

   localparam int SAMPLE_W = 16;
   localparam int ONE_G_W  = 15;
   localparam int TOL_W    = 13;
   localparam int LEVEL_W  = 4;
   localparam int FACE_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = ONE_G_W;
   localparam int CALC_W   = 20;

   localparam logic [ONE_G_W-1:0] ONE_G_RESET = 15'd8192;
   localparam logic [TOL_W-1:0]   TOL_RESET   = 13'd2000;
   localparam logic               LIMIT_RESET = 1'b0;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [LEVEL_W-1:0]  level_type;
   typedef logic signed [CALC_W-1:0]   calc_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ONE_G_COUNTS   = 2'd0,
      CSR_BAND_TOLERANCE = 2'd1,
      CSR_LIMIT_TWO_G    = 2'd2
   } csr_index_type;

   typedef enum logic [FACE_W-1:0] {
      FACE_POS_X = 3'd0,
      FACE_POS_Y = 3'd1,
      FACE_POS_Z = 3'd2,
      FACE_NEG_X = 3'd3,
      FACE_NEG_Y = 3'd4,
      FACE_NEG_Z = 3'd5
   } face_type;

   localparam level_type LVL_P4 = 4'sd4;
   localparam level_type LVL_P3 = 4'sd3;
   localparam level_type LVL_P2 = 4'sd2;
   localparam level_type LVL_P1 = 4'sd1;
   localparam level_type LVL_Z  = 4'sd0;
   localparam level_type LVL_N1 = -4'sd1;
   localparam level_type LVL_N2 = -4'sd2;
   localparam level_type LVL_N3 = -4'sd3;
   localparam level_type LVL_N4 = -4'sd4;

   function automatic logic in_win(input calc_type p, input calc_type c, input calc_type t);
      return (p > c - t) && (p < c + t);
   endfunction

   function automatic level_type quantize(input sample_type sample,
                                          input logic [ONE_G_W-1:0] one_g,
                                          input logic [TOL_W-1:0] tol,
                                          input logic limit,
                                          input level_type keep);
      calc_type p;
      calc_type g1;
      calc_type g2;
      calc_type g3;
      calc_type g4;
      calc_type t;
      level_type r;
      p  = {{(CALC_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
      g1 = {{(CALC_W-ONE_G_W){1'b0}}, one_g};
      t  = {{(CALC_W-TOL_W){1'b0}}, tol};
      g2 = g1 <<< 1;
      g3 = g2 + g1;
      g4 = g1 <<< 2;
      r  = keep;
      if (limit) begin
         if (p > g2 - t)                     r = LVL_P2;
         else if (in_win(p, g1, t))          r = LVL_P1;
         else if (p > t - g1 && p < g1 - t)  r = LVL_Z;
         else if (in_win(p, -g1, t))         r = LVL_N1;
         else if (p < t - g2)                r = LVL_N2;
      end else begin
         if (p > g4 + t)                     r = LVL_P4;
         else if (in_win(p, g4, t))          r = LVL_P4;
         else if (in_win(p, g3, t))          r = LVL_P3;
         else if (in_win(p, g2, t))          r = LVL_P2;
         else if (in_win(p, g1, t))          r = LVL_P1;
         else if (p > t - g1 && p < g1 - t)  r = LVL_Z;
         else if (in_win(p, -g1, t))         r = LVL_N1;
         else if (in_win(p, -g2, t))         r = LVL_N2;
         else if (in_win(p, -g3, t))         r = LVL_N3;
         else if (in_win(p, -g4, t))         r = LVL_N4;
         else if (p < -g4 - t)               r = LVL_N4;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/agqfd_req_if.sv @@
`default_nettype none

interface agqfd_req_if;
   logic                  valid;
   logic                  ready;
   agqfd_pkg::sample_type accel_x;
   agqfd_pkg::sample_type accel_y;
   agqfd_pkg::sample_type accel_z;

   modport source (output valid, output accel_x, output accel_y, output accel_z,
                   input ready);
   modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/agqfd_rsp_if.sv @@
`default_nettype none

interface agqfd_rsp_if;
   logic                                valid;
   logic                                ready;
   agqfd_pkg::level_type                level_x;
   agqfd_pkg::level_type                level_y;
   agqfd_pkg::level_type                level_z;
   logic [agqfd_pkg::FACE_W-1:0]        face_code;
   logic                                face_valid;

   modport source (output valid, output level_x, output level_y, output level_z,
                   output face_code, output face_valid, input ready);
   modport sink   (input valid, input level_x, input level_y, input level_z,
                   input face_code, input face_valid, output ready);
endinterface

`default_nettype wire

@@ rtl/accel_g_quantizer_face_detect_unit.sv @@
`default_nettype none

// channel   dir  handshake     payload
// req_bus   in   valid/ready   accel_x, accel_y, accel_z
// rsp_bus   out  valid/ready   level_x, level_y, level_z, face_code, face_valid
// csr_*     in   csr_wen       csr_index, csr_wdata
//
// One beat per cycle while rsp_bus is ready; beats pass input, then output registers.
// The held levels form the only loop: they update as a beat leaves the input register.
// Synchronous reset clears valids and held levels and loads the CSR defaults only.
// A stalled rsp_bus holds its beat; the input register still takes one more beat.

module accel_g_quantizer_face_detect_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   agqfd_req_if.sink                                req_bus,
   agqfd_rsp_if.source                              rsp_bus,
   input  wire logic                                csr_wen,
   input  wire logic [agqfd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [agqfd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [agqfd_pkg::ONE_G_W-1:0] one_g_ff;
   logic [agqfd_pkg::TOL_W-1:0]   tol_ff;
   logic                          limit_ff;

   logic                  in_valid_ff;
   agqfd_pkg::sample_type ax_ff;
   agqfd_pkg::sample_type ay_ff;
   agqfd_pkg::sample_type az_ff;

   agqfd_pkg::level_type  held_x_ff;
   agqfd_pkg::level_type  held_y_ff;
   agqfd_pkg::level_type  held_z_ff;
   agqfd_pkg::level_type  held_x_in;
   agqfd_pkg::level_type  held_y_in;
   agqfd_pkg::level_type  held_z_in;

   logic                  out_valid_ff;
   agqfd_pkg::face_type   face_ff;
   agqfd_pkg::face_type   face_in;
   logic                  face_valid_ff;
   logic                  face_valid_in;

   logic                  advance;
   logic                  req_take;
   logic [1:0]            hits;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         one_g_ff <= agqfd_pkg::ONE_G_RESET;
         tol_ff   <= agqfd_pkg::TOL_RESET;
         limit_ff <= agqfd_pkg::LIMIT_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            agqfd_pkg::CSR_ONE_G_COUNTS:   one_g_ff <= csr_wdata;
            agqfd_pkg::CSR_BAND_TOLERANCE: tol_ff   <= csr_wdata[agqfd_pkg::TOL_W-1:0];
            agqfd_pkg::CSR_LIMIT_TWO_G:    limit_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      held_x_in = agqfd_pkg::quantize(ax_ff, one_g_ff, tol_ff, limit_ff, held_x_ff);
      held_y_in = agqfd_pkg::quantize(ay_ff, one_g_ff, tol_ff, limit_ff, held_y_ff);
      held_z_in = agqfd_pkg::quantize(az_ff, one_g_ff, tol_ff, limit_ff, held_z_ff);

      hits    = 2'd0;
      face_in = agqfd_pkg::FACE_POS_X;
      if (held_x_in == agqfd_pkg::LVL_P1 || held_x_in == agqfd_pkg::LVL_N1) begin
         hits    = hits + 2'd1;
         face_in = (held_x_in == agqfd_pkg::LVL_P1) ? agqfd_pkg::FACE_POS_X
                                                    : agqfd_pkg::FACE_NEG_X;
      end
      if (held_y_in == agqfd_pkg::LVL_P1 || held_y_in == agqfd_pkg::LVL_N1) begin
         hits    = hits + 2'd1;
         face_in = (held_y_in == agqfd_pkg::LVL_P1) ? agqfd_pkg::FACE_POS_Y
                                                    : agqfd_pkg::FACE_NEG_Y;
      end
      if (held_z_in == agqfd_pkg::LVL_P1 || held_z_in == agqfd_pkg::LVL_N1) begin
         hits    = hits + 2'd1;
         face_in = (held_z_in == agqfd_pkg::LVL_P1) ? agqfd_pkg::FACE_POS_Z
                                                    : agqfd_pkg::FACE_NEG_Z;
      end
      face_valid_in = (hits == 2'd1);
      if (!face_valid_in) begin
         face_in = agqfd_pkg::FACE_POS_X;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         held_x_ff    <= agqfd_pkg::LVL_Z;
         held_y_ff    <= agqfd_pkg::LVL_Z;
         held_z_ff    <= agqfd_pkg::LVL_Z;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            held_x_ff    <= held_x_in;
            held_y_ff    <= held_y_in;
            held_z_ff    <= held_z_in;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         ax_ff <= req_bus.accel_x;
         ay_ff <= req_bus.accel_y;
         az_ff <= req_bus.accel_z;
      end
      if (advance) begin
         face_ff       <= face_in;
         face_valid_ff <= face_valid_in;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.level_x    = held_x_ff;
   assign rsp_bus.level_y    = held_y_ff;
   assign rsp_bus.level_z    = held_z_ff;
   assign rsp_bus.face_code  = face_ff;
   assign rsp_bus.face_valid = face_valid_ff;

endmodule

`default_nettype wire

@@ bench/tb_accel_g_quantizer_face_detect_unit.sv @@
`timescale 1ns / 100ps

module tb_accel_g_quantizer_face_detect_unit;

   localparam logic [agqfd_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 80;
   localparam int QUIET_LIMIT = 2000;
   localparam int BEATS_PER_PHASE = 150;
   localparam int PHASES = 9;
   localparam agqfd_pkg::face_type UP_FACE [3] =
      '{agqfd_pkg::FACE_POS_X, agqfd_pkg::FACE_POS_Y, agqfd_pkg::FACE_POS_Z};
   localparam agqfd_pkg::face_type DOWN_FACE [3] =
      '{agqfd_pkg::FACE_NEG_X, agqfd_pkg::FACE_NEG_Y, agqfd_pkg::FACE_NEG_Z};

   typedef struct packed {
      agqfd_pkg::level_type         lx;
      agqfd_pkg::level_type         ly;
      agqfd_pkg::level_type         lz;
      logic [agqfd_pkg::FACE_W-1:0] face;
      logic                         valid;
   } face_report_type;

   typedef struct {
      logic                            is_csr;
      logic [agqfd_pkg::CSR_IDX_W-1:0] idx;
      int unsigned                     wdata;
      int                              ax;
      int                              ay;
      int                              az;
      logic                            known;
      face_report_type                 want;
   } drill_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wen;
   logic [agqfd_pkg::CSR_IDX_W-1:0] csr_index;
   logic [agqfd_pkg::CSR_DATA_W-1:0] csr_wdata;

   logic accept_rsp = 1'b0;
   logic calm = 1'b0;
   int unsigned hold_asks = 0;
   int unsigned hold_done = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   int mismatches = 0;
   int samples_sent = 0;
   int reports_seen = 0;
   int faces_seen = 0;
   int csr_writes = 0;

   int unsigned cfg_one_g;
   int unsigned cfg_tol;
   logic cfg_limit;
   agqfd_pkg::level_type held [3];

   face_report_type face_reports_due[$];
   drill_row_type drill_rows[$];

   agqfd_req_if req_bus ();
   agqfd_rsp_if rsp_bus ();

   assign rsp_bus.ready = accept_rsp;

   accel_g_quantizer_face_detect_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic agqfd_pkg::level_type whole_g_level(input int p,
                                                          input agqfd_pkg::level_type keep);
      int g;
      int t;
      int k;
      logic found;
      agqfd_pkg::level_type lv;
      g = int'(cfg_one_g);
      t = int'(cfg_tol);
      lv = keep;
      found = 1'b0;
      if (cfg_limit) begin
         if (p > 2 * g - t) lv = agqfd_pkg::LVL_P2;
         else if (p > g - t && p < g + t) lv = agqfd_pkg::LVL_P1;
         else if (p > t - g && p < g - t) lv = agqfd_pkg::LVL_Z;
         else if (p > -g - t && p < -g + t) lv = agqfd_pkg::LVL_N1;
         else if (p < t - 2 * g) lv = agqfd_pkg::LVL_N2;
      end else if (p > 4 * g + t) begin
         lv = agqfd_pkg::LVL_P4;
      end else begin
         for (k = 4; k >= 1 && !found; k--) begin
            if (p > k * g - t && p < k * g + t) begin
               lv = agqfd_pkg::level_type'(k);
               found = 1'b1;
            end
         end
         if (!found && p > t - g && p < g - t) begin
            lv = agqfd_pkg::LVL_Z;
            found = 1'b1;
         end
         for (k = 1; k <= 4 && !found; k++) begin
            if (p > -k * g - t && p < -k * g + t) begin
               lv = agqfd_pkg::level_type'(-k);
               found = 1'b1;
            end
         end
         if (!found && p < -4 * g - t) lv = agqfd_pkg::LVL_N4;
      end
      return lv;
   endfunction

   function automatic face_report_type track_orientation(input agqfd_pkg::sample_type ax,
                                                         input agqfd_pkg::sample_type ay,
                                                         input agqfd_pkg::sample_type az);
      agqfd_pkg::sample_type s [3];
      int hits;
      logic [agqfd_pkg::FACE_W-1:0] face;
      face_report_type r;
      s[0] = ax;
      s[1] = ay;
      s[2] = az;
      hits = 0;
      face = '0;
      for (int a = 0; a < 3; a++) begin
         held[a] = whole_g_level(int'(s[a]), held[a]);
         if (held[a] == agqfd_pkg::LVL_P1) begin
            hits++;
            face = UP_FACE[a];
         end else if (held[a] == agqfd_pkg::LVL_N1) begin
            hits++;
            face = DOWN_FACE[a];
         end
      end
      r.lx = held[0];
      r.ly = held[1];
      r.lz = held[2];
      r.face = (hits == 1) ? face : '0;
      r.valid = (hits == 1);
      return r;
   endfunction

   function automatic agqfd_pkg::sample_type pick_sample();
      int g;
      int t;
      int v;
      g = int'(cfg_one_g);
      t = int'(cfg_tol);
      case ($urandom_range(9))
         0, 1: v = int'($urandom_range(65535)) - 32768;
         2: v = $urandom_range(1) ? 32767 : -32768;
         3: v = (int'($urandom_range(8)) - 4) * g + ($urandom_range(1) ? t : -t);
         default: v = (int'($urandom_range(10)) - 5) * g
                      + int'($urandom_range(2 * t + 4)) - (t + 2);
      endcase
      if (v > 32767) v = 32767;
      else if (v < -32768) v = -32768;
      return agqfd_pkg::sample_type'(v);
   endfunction

   function automatic void add_csr(input logic [agqfd_pkg::CSR_IDX_W-1:0] idx,
                                   input int unsigned data);
      drill_row_type r;
      r = '{1'b1, idx, data, 0, 0, 0, 1'b0, '0};
      drill_rows.push_back(r);
   endfunction

   function automatic void add_beat(input int ax, input int ay, input int az);
      drill_row_type r;
      r = '{1'b0, '0, 0, ax, ay, az, 1'b0, '0};
      drill_rows.push_back(r);
   endfunction

   function automatic void add_known(input int ax, input int ay, input int az,
                                     input face_report_type want);
      drill_row_type r;
      r = '{1'b0, '0, 0, ax, ay, az, 1'b1, want};
      drill_rows.push_back(r);
   endfunction

   task automatic write_csr(input logic [agqfd_pkg::CSR_IDX_W-1:0] idx,
                            input int unsigned data);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[agqfd_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_writes++;
      case (idx)
         agqfd_pkg::CSR_ONE_G_COUNTS:   cfg_one_g = data[agqfd_pkg::ONE_G_W-1:0];
         agqfd_pkg::CSR_BAND_TOLERANCE: cfg_tol = data[agqfd_pkg::TOL_W-1:0];
         agqfd_pkg::CSR_LIMIT_TWO_G:    cfg_limit = data[0];
         default: ;
      endcase
   endtask

   task automatic drain_results();
      if (req_bus.valid) req_bus.valid <= 1'b0;
      while (face_reports_due.size() != 0) @(posedge clock);
   endtask

   task automatic offer_sample(input agqfd_pkg::sample_type ax,
                               input agqfd_pkg::sample_type ay,
                               input agqfd_pkg::sample_type az,
                               input logic known, input face_report_type want);
      face_report_type calc;
      req_bus.valid   <= 1'b1;
      req_bus.accel_x <= ax;
      req_bus.accel_y <= ay;
      req_bus.accel_z <= az;
      do @(posedge clock); while (!req_bus.ready);
      samples_sent++;
      calc = track_orientation(ax, ay, az);
      face_reports_due.push_back(known ? want : calc);
      if (!calm && $urandom_range(99) < 12) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin : rsp_side
      face_report_type due;
      if (reset) begin
         accept_rsp <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            reports_seen++;
            if (rsp_bus.face_valid) faces_seen++;
            if (face_reports_due.size() == 0) begin
               $error("rsp beat with no sample outstanding");
               mismatches++;
            end else begin
               due = face_reports_due.pop_front();
               if (rsp_bus.level_x !== due.lx) begin
                  $error("level_x: expected %0d, got %0d", due.lx, rsp_bus.level_x);
                  mismatches++;
               end
               if (rsp_bus.level_y !== due.ly) begin
                  $error("level_y: expected %0d, got %0d", due.ly, rsp_bus.level_y);
                  mismatches++;
               end
               if (rsp_bus.level_z !== due.lz) begin
                  $error("level_z: expected %0d, got %0d", due.lz, rsp_bus.level_z);
                  mismatches++;
               end
               if (rsp_bus.face_code !== due.face) begin
                  $error("face_code: expected %0d, got %0d", due.face, rsp_bus.face_code);
                  mismatches++;
               end
               if (rsp_bus.face_valid !== due.valid) begin
                  $error("face_valid: expected %0d, got %0d", due.valid, rsp_bus.face_valid);
                  mismatches++;
               end
            end
         end
         // hold off for a long stretch on request, otherwise stall at random unless calm
         if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            accept_rsp <= 1'b0;
         end else if (hold_done != hold_asks) begin
            hold_done  <= hold_asks;
            hold_left  <= HOLD_CYCLES;
            accept_rsp <= 1'b0;
         end else begin
            accept_rsp <= calm || ($urandom_range(99) >= 23);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || csr_wen) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("accel_g_quantizer_face_detect_unit: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      drill_row_type row;
      int g;
      int t;
      int lim;

      reset           <= 1'b1;
      csr_wen         <= 1'b0;
      csr_index       <= agqfd_pkg::CSR_ONE_G_COUNTS;
      csr_wdata       <= '0;
      req_bus.valid   <= 1'b0;
      req_bus.accel_x <= '0;
      req_bus.accel_y <= '0;
      req_bus.accel_z <= '0;
      cfg_one_g = agqfd_pkg::ONE_G_RESET;
      cfg_tol   = agqfd_pkg::TOL_RESET;
      cfg_limit = agqfd_pkg::LIMIT_RESET;
      for (int a = 0; a < 3; a++) held[a] = agqfd_pkg::LVL_Z;

      // levels after reset, extremes, held levels on boundaries and in gaps
      add_known(0, 0, 0, '{agqfd_pkg::LVL_Z, agqfd_pkg::LVL_Z, agqfd_pkg::LVL_Z,
                           3'd0, 1'b0});
      add_known(8192, 0, 0, '{agqfd_pkg::LVL_P1, agqfd_pkg::LVL_Z, agqfd_pkg::LVL_Z,
                              agqfd_pkg::FACE_POS_X, 1'b1});
      add_known(32767, -32768, 8192, '{agqfd_pkg::LVL_P4, agqfd_pkg::LVL_N4,
                                       agqfd_pkg::LVL_P1, agqfd_pkg::FACE_POS_Z, 1'b1});
      add_known(-8192, 0, 0, '{agqfd_pkg::LVL_N1, agqfd_pkg::LVL_Z, agqfd_pkg::LVL_Z,
                               agqfd_pkg::FACE_NEG_X, 1'b1});
      add_known(6192, 10192, -10192, '{agqfd_pkg::LVL_N1, agqfd_pkg::LVL_Z,
                                       agqfd_pkg::LVL_Z, agqfd_pkg::FACE_NEG_X, 1'b1});
      add_known(12000, -12000, 20000, '{agqfd_pkg::LVL_N1, agqfd_pkg::LVL_Z,
                                        agqfd_pkg::LVL_Z, agqfd_pkg::FACE_NEG_X, 1'b1});
      add_known(8192, -8192, 16384, '{agqfd_pkg::LVL_P1, agqfd_pkg::LVL_N1,
                                      agqfd_pkg::LVL_P2, 3'd0, 1'b0});
      add_known(24576, 8192, -24576, '{agqfd_pkg::LVL_P3, agqfd_pkg::LVL_P1,
                                       agqfd_pkg::LVL_N3, agqfd_pkg::FACE_POS_Y, 1'b1});
      add_known(-16384, -32768, -1, '{agqfd_pkg::LVL_N2, agqfd_pkg::LVL_N4,
                                      agqfd_pkg::LVL_Z, 3'd0, 1'b0});
      add_known(1, 0, -8192, '{agqfd_pkg::LVL_Z, agqfd_pkg::LVL_Z, agqfd_pkg::LVL_N1,
                               agqfd_pkg::FACE_NEG_Z, 1'b1});
      add_csr(agqfd_pkg::CSR_LIMIT_TWO_G, 1);
      add_known(32767, -32768, 8192, '{agqfd_pkg::LVL_P2, agqfd_pkg::LVL_N2,
                                       agqfd_pkg::LVL_P1, agqfd_pkg::FACE_POS_Z, 1'b1});
      add_known(14384, -14384, 12000, '{agqfd_pkg::LVL_P2, agqfd_pkg::LVL_N2,
                                        agqfd_pkg::LVL_P1, agqfd_pkg::FACE_POS_Z, 1'b1});
      add_known(14385, -8192, 0, '{agqfd_pkg::LVL_P2, agqfd_pkg::LVL_N1,
                                   agqfd_pkg::LVL_Z, agqfd_pkg::FACE_NEG_Y, 1'b1});
      add_csr(agqfd_pkg::CSR_ONE_G_COUNTS, 0);
      add_beat(0, 2000, -2001);
      add_beat(5, -5, 2001);
      add_csr(CSR_UNUSED, 32767);
      add_beat(-2000, 3000, 0);
      add_csr(agqfd_pkg::CSR_LIMIT_TWO_G, 0);
      add_beat(-2000, 3000, 2000);
      add_csr(agqfd_pkg::CSR_ONE_G_COUNTS, 16384);
      add_csr(agqfd_pkg::CSR_BAND_TOLERANCE, 8191);
      add_beat(32767, -32768, 16384);
      add_csr(agqfd_pkg::CSR_ONE_G_COUNTS, 32767);
      add_csr(agqfd_pkg::CSR_BAND_TOLERANCE, 0);
      add_beat(32767, -32767, 0);
      add_csr(agqfd_pkg::CSR_ONE_G_COUNTS, 1);
      add_csr(agqfd_pkg::CSR_BAND_TOLERANCE, 8191);
      add_beat(8192, -8193, 3);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (drill_rows[n]) begin
         row = drill_rows[n];
         if (row.is_csr) begin
            drain_results();
            write_csr(row.idx, row.wdata);
         end else begin
            csr_wen <= 1'b0;
            offer_sample(agqfd_pkg::sample_type'(row.ax), agqfd_pkg::sample_type'(row.ay),
                         agqfd_pkg::sample_type'(row.az), row.known, row.want);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin g = agqfd_pkg::ONE_G_RESET; t = agqfd_pkg::TOL_RESET; lim = 0; end
            1: begin g = agqfd_pkg::ONE_G_RESET; t = agqfd_pkg::TOL_RESET; lim = 1; end
            2: begin g = 1; t = 0; lim = 0; end
            3: begin g = 16384; t = 8191; lim = 1; end
            4: begin g = 32767; t = 8191; lim = 0; end
            default: begin
               g = $urandom_range(16384, 1);
               t = ($urandom_range(3) == 0) ? $urandom_range(8191) : $urandom_range(g / 2);
               lim = $urandom_range(1);
            end
         endcase
         drain_results();
         write_csr(agqfd_pkg::CSR_ONE_G_COUNTS, g);
         write_csr(agqfd_pkg::CSR_BAND_TOLERANCE, t);
         write_csr(agqfd_pkg::CSR_LIMIT_TWO_G, lim);
         csr_wen <= 1'b0;
         calm <= (phase == 1);
         for (int i = 0; i < BEATS_PER_PHASE; i++) begin
            if (phase == 3 && i == 30) hold_asks <= hold_asks + 1;
            if (phase == 6 && i == 75) drain_results();
            offer_sample(pick_sample(), pick_sample(), pick_sample(), 1'b0, '0);
         end
      end

      drain_results();
      repeat (8) @(posedge clock);

      $display("%0d sample beats sent, %0d rsp beats checked (%0d with a face)",
               samples_sent, reports_seen, faces_seen);
      $display("%0d register writes across full-range, two-g, zero and extreme one-g settings",
               csr_writes);
      if (mismatches == 0 && face_reports_due.size() == 0)
         $display("accel_g_quantizer_face_detect_unit: match");
      else
         $display("accel_g_quantizer_face_detect_unit: mismatch");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/agqfd_pkg.sv
rtl/agqfd_req_if.sv
rtl/agqfd_rsp_if.sv
rtl/accel_g_quantizer_face_detect_unit.sv
bench/tb_accel_g_quantizer_face_detect_unit.sv
